// ===== src/periodic_event_wakeup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic event wakeup block
// Concurrent checks on clk/reset that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_WAKEUP_ASSERT_SVH
`define PERIODIC_EVENT_WAKEUP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PEW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle implies a condition in the next.
`define PEW_ASSERT_NEXT(name, clk, rst_n, cond, nxt, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);
`else
`define PEW_ASSERT(name, clk, rst_n, prop, msg)
`define PEW_ASSERT_NEXT(name, clk, rst_n, cond, nxt, msg)
`endif

`endif

// ===== src/pew_pkg.sv =====
// ----------------------------------------------------------------------------
// pew_pkg
// Shared widths, function codes, register indexes and types.
// ----------------------------------------------------------------------------
package pew_pkg;

  localparam int FUNC_W     = 1;
  localparam int NOW_W      = 32;
  localparam int SRC_W      = 2;
  localparam int TASK_W     = 6;
  localparam int WOKEN_W    = 64;
  localparam int FIRED_W    = 4;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int PREG_NUM   = 4;
  localparam int PREG_IDX_W = 2;
  // widest source address (up to eight sources)
  localparam int SRC_MAX_W  = 3;

  localparam logic [NOW_W-1:0] TIME_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_WAIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_C = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_D = 8'd3;

  // Reset period of each period register.
  function automatic logic [PERIOD_W-1:0] pew_reset_period(input logic [PREG_IDX_W-1:0] idx);
    logic [PERIOD_W-1:0] val;
    case (idx)
      2'd0:    val = 16'd100;
      2'd1:    val = 16'd200;
      2'd2:    val = 16'd500;
      default: val = 16'd50;
    endcase
    return val;
  endfunction

  // Access strobes from the sequencer to the state memory.
  typedef struct packed {
    logic rd;
    logic mt_we;
    logic ws_we;
  } pew_mem_ctl_t;

endpackage

// ===== src/pew_chan_if.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface pew_in_if;
  import pew_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [NOW_W-1:0]    now_ms;
  logic [SRC_W-1:0]    src_id;
  logic [TASK_W-1:0]   task_req;

  modport source (output valid, func, now_ms, src_id, task_req, input ready);
  modport sink   (input valid, func, now_ms, src_id, task_req, output ready);
endinterface

interface pew_out_if;
  import pew_pkg::*;

  logic               valid;
  logic               ready;
  logic [WOKEN_W-1:0] woken_tasks;
  logic [FIRED_W-1:0] fired_sources;

  modport source (output valid, woken_tasks, fired_sources, input ready);
  modport sink   (input valid, woken_tasks, fired_sources, output ready);
endinterface

interface pew_cfg_if;
  import pew_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pew_rem.sv =====
// ----------------------------------------------------------------------------
// pew_rem
// Iterative remainder unit: 32-bit dividend mod 16-bit divisor, two bits per cycle.
// ----------------------------------------------------------------------------
`include "periodic_event_wakeup_assert.svh"

module pew_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pew_pkg::NOW_W-1:0]     dividend_i,
  input  logic [pew_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [pew_pkg::PERIOD_W-1:0]  rem_o
);
  import pew_pkg::*;

  localparam int BITS_PER_CYC = 2;
  localparam int CYCLES       = NOW_W / BITS_PER_CYC;
  localparam int CNT_W        = $clog2(CYCLES);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [NOW_W-1:0]    dvd_q, dvd_d;
  logic [PERIOD_W-1:0] dvs_q;
  logic [PERIOD_W:0]   trial;

  // Restoring steps: shift in a dividend bit, subtract when it fits.
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = '0;
    for (int b = 0; b < BITS_PER_CYC; b++) begin
      trial = {rem_d, dvd_d[NOW_W-1]};
      dvd_d = {dvd_d[NOW_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `PEW_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "remainder unit restarted while busy")
  `PEW_ASSERT(a_rem_below, clk_i, rst_ni, done_q |-> (rem_q < dvs_q), "remainder not below divisor")
  `PEW_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i, busy_q, "remainder unit did not start")

endmodule

// ===== src/pew_state_mem.sv =====
// ----------------------------------------------------------------------------
// pew_state_mem
// Match time and waiting set memories, registered read, with per-entry valid bits.
// ----------------------------------------------------------------------------
`include "periodic_event_wakeup_assert.svh"

module pew_state_mem #(
  parameter int SOURCE_COUNT = 4,
  parameter int TASK_COUNT   = 64,
  parameter int AW           = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pew_pkg::pew_mem_ctl_t       ctl_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [pew_pkg::NOW_W-1:0]   mt_wdata_i,
  input  logic [TASK_COUNT-1:0]       ws_wdata_i,
  output logic [pew_pkg::NOW_W-1:0]   mt_rdata_o,
  output logic [TASK_COUNT-1:0]       ws_rdata_o
);
  import pew_pkg::*;

  logic [NOW_W-1:0]      mt_mem [SOURCE_COUNT];
  logic [TASK_COUNT-1:0] ws_mem [SOURCE_COUNT];
  logic [SOURCE_COUNT-1:0] mt_vld_q, ws_vld_q;
  logic                  mt_hit_q, ws_hit_q;
  logic [NOW_W-1:0]      mt_rd_q;
  logic [TASK_COUNT-1:0] ws_rd_q;
  logic [AW-1:0]         addr_q;
  logic [SRC_MAX_W-1:0]  addr_ext;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mt_we) begin
      mt_mem[addr_i] <= mt_wdata_i;
    end
    if (ctl_i.ws_we) begin
      ws_mem[addr_i] <= ws_wdata_i;
    end
    if (ctl_i.rd) begin
      mt_rd_q <= mt_mem[addr_i];
      ws_rd_q <= ws_mem[addr_i];
      addr_q  <= addr_i;
    end
  end

  // An entry never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_vld_q <= '0;
      ws_vld_q <= '0;
      mt_hit_q <= 1'b0;
      ws_hit_q <= 1'b0;
    end else begin
      if (ctl_i.mt_we) begin
        mt_vld_q[addr_i] <= 1'b1;
      end
      if (ctl_i.ws_we) begin
        ws_vld_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        mt_hit_q <= mt_vld_q[addr_i];
        ws_hit_q <= ws_vld_q[addr_i];
      end
    end
  end

  assign addr_ext   = SRC_MAX_W'(addr_q);
  assign mt_rdata_o = mt_hit_q ? mt_rd_q
                               : NOW_W'(pew_reset_period(addr_ext[PREG_IDX_W-1:0]));
  assign ws_rdata_o = ws_hit_q ? ws_rd_q : '0;

  `PEW_ASSERT(a_rd_wr_apart, clk_i, rst_ni, ctl_i.rd |-> !(ctl_i.mt_we || ctl_i.ws_we), "read and write in one cycle")

endmodule

// ===== src/periodic_event_wakeup.sv =====
// ----------------------------------------------------------------------------
// periodic_event_wakeup
// Periodic event sources with per-source waiting task sets.
//
// in_i carries one item per transfer: a tick (func = tick) with the current
// millisecond count, or a wait (func = wait) that parks task_req on src_id.
// Every item gives exactly one result on out_o: the tasks released and the
// sources that fired (both zero for a wait). cfg_i writes the four 16-bit
// period registers; write only while the block is idle.
// Sequence: a wait reads its source entry, writes the waiting set back and
// loads the result (a dropped out-of-range wait goes straight to the
// result). A tick reads and checks each source in turn; for each source that
// fires it waits on the 2-bit-per-cycle remainder unit and writes the new
// match time, then it loads the result. One item is in work at a time.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, the block holds the next result until the
// output register frees up. Reset loads the reset periods and marks every
// memory entry unwritten, so match times read as the reset periods and
// waiting sets as empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "periodic_event_wakeup_assert.svh"

module periodic_event_wakeup #(
  parameter int SOURCE_COUNT = 4,
  parameter int TASK_COUNT   = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pew_in_if.sink    in_i,
  pew_out_if.source out_o,
  pew_cfg_if.sink   cfg_i
);
  import pew_pkg::*;

  localparam int AW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // take an item
  localparam logic [2:0] ST_RD   = 3'd1;  // read one source entry
  localparam logic [2:0] ST_CHK  = 3'd2;  // compare, clear or add waiters
  localparam logic [2:0] ST_DIV  = 3'd3;  // wait on remainder, write match
  localparam logic [2:0] ST_DONE = 3'd4;  // load the output register

  logic [2:0]            state_q, state_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [NOW_W-1:0]      now_q, now_d;
  logic [TASK_W-1:0]     task_q, task_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [TASK_COUNT-1:0] woken_q, woken_d;
  logic [FIRED_W-1:0]    fired_q, fired_d;
  logic [PERIOD_W-1:0]   period_q [PREG_NUM];

  logic                  out_valid_q, out_valid_d;
  logic [WOKEN_W-1:0]    out_woken_q, out_woken_d;
  logic [FIRED_W-1:0]    out_fired_q, out_fired_d;
  logic                  out_load;

  pew_mem_ctl_t          mem_ctl;
  logic [NOW_W-1:0]      mt_wdata, mt_rdata;
  logic [TASK_COUNT-1:0] ws_wdata, ws_rdata;

  logic                  rem_start, rem_done;
  logic [NOW_W-1:0]      rem_dividend;
  logic [PERIOD_W-1:0]   rem_val;

  logic [SRC_MAX_W-1:0]  idx_ext;
  logic [PERIOD_W-1:0]   period_raw, period_eff;
  logic [NOW_W:0]        next_sum;
  logic                  last_src;
  logic                  in_xfer;
  logic                  wait_ok;

  // ---------------------------------------------------------------------------
  // Period registers. A write past the last register is dropped.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PREG_NUM; i++) begin
        period_q[i] <= pew_reset_period(PREG_IDX_W'(i));
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PERIOD_A: period_q[0] <= cfg_i.data;
        REG_PERIOD_B: period_q[1] <= cfg_i.data;
        REG_PERIOD_C: period_q[2] <= cfg_i.data;
        REG_PERIOD_D: period_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sources above the register count share registers modulo four; a zero
  // period acts as one.
  assign idx_ext    = SRC_MAX_W'(idx_q);
  assign period_raw = period_q[idx_ext[PREG_IDX_W-1:0]];
  assign period_eff = (period_raw == '0) ? PERIOD_W'(1) : period_raw;

  // ---------------------------------------------------------------------------
  // Match advance: next = now + period - ((now - match) mod period),
  // saturating at the top of the time range.
  // ---------------------------------------------------------------------------
  assign rem_dividend = now_q - mt_rdata;
  assign next_sum     = {1'b0, now_q} + (NOW_W + 1)'(period_eff) - (NOW_W + 1)'(rem_val);
  assign mt_wdata     = next_sum[NOW_W] ? TIME_MAX : next_sum[NOW_W-1:0];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign wait_ok    = (int'(in_i.src_id) < SOURCE_COUNT) && (int'(in_i.task_req) < TASK_COUNT);
  assign last_src   = (idx_q == AW'(SOURCE_COUNT - 1));

  // ---------------------------------------------------------------------------
  // Sequencer: one item at a time; any write-back of a memory entry lands
  // before the next read, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    now_d     = now_q;
    task_d    = task_q;
    idx_d     = idx_q;
    woken_d   = woken_q;
    fired_d   = fired_q;
    mem_ctl   = '0;
    ws_wdata  = '0;
    rem_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          func_d  = in_i.func;
          now_d   = in_i.now_ms;
          task_d  = in_i.task_req;
          woken_d = '0;
          fired_d = '0;
          if (in_i.func == FUNC_TICK) begin
            idx_d   = '0;
            state_d = ST_RD;
          end else if (wait_ok) begin
            idx_d   = AW'(in_i.src_id);
            state_d = ST_RD;
          end else begin
            // drop an out-of-range wait, still answer it
            state_d = ST_DONE;
          end
        end
      end

      ST_RD: begin
        mem_ctl.rd = 1'b1;
        state_d    = ST_CHK;
      end

      ST_CHK: begin
        if (func_q == FUNC_WAIT) begin
          mem_ctl.ws_we = 1'b1;
          ws_wdata      = ws_rdata | (TASK_COUNT'(1) << task_q);
          state_d       = ST_DONE;
        end else if (now_q >= mt_rdata) begin
          // fire: release and clear the waiters, then advance the match
          woken_d       = woken_q | ws_rdata;
          fired_d       = fired_q | FIRED_W'(FIRED_W'(1) << idx_q);
          mem_ctl.ws_we = 1'b1;
          rem_start     = 1'b1;
          state_d       = ST_DIV;
        end else if (last_src) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_RD;
        end
      end

      ST_DIV: begin
        if (rem_done) begin
          mem_ctl.mt_we = 1'b1;
          if (last_src) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_RD;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load a result, drop it after its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_woken_d = out_woken_q;
    out_fired_d = out_fired_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_woken_d = WOKEN_W'(woken_q);
      out_fired_d = fired_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    now_q       <= now_d;
    task_q      <= task_d;
    idx_q       <= idx_d;
    woken_q     <= woken_d;
    fired_q     <= fired_d;
    out_woken_q <= out_woken_d;
    out_fired_q <= out_fired_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.woken_tasks   = out_woken_q;
  assign out_o.fired_sources = out_fired_q;

  // ---------------------------------------------------------------------------
  // Units
  // ---------------------------------------------------------------------------
  pew_state_mem #(
    .SOURCE_COUNT (SOURCE_COUNT),
    .TASK_COUNT   (TASK_COUNT),
    .AW           (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mem_ctl),
    .addr_i     (idx_q),
    .mt_wdata_i (mt_wdata),
    .ws_wdata_i (ws_wdata),
    .mt_rdata_o (mt_rdata),
    .ws_rdata_o (ws_rdata)
  );

  pew_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (period_eff),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  `PEW_ASSERT(a_done_in_div, clk_i, rst_ni, rem_done |-> (state_q == ST_DIV), "remainder finished outside advance")
  `PEW_ASSERT(a_load_free, clk_i, rst_ni, out_load |-> (!out_valid_q || out_o.ready), "result overwrote a pending result")
  `PEW_ASSERT(a_wait_quiet, clk_i, rst_ni, (out_load && (func_q == FUNC_WAIT)) |-> ((woken_q == '0) && (fired_q == '0)), "wait item reported wakeups")

endmodule

// ===== verif/pew_wake_checker.sv =====
// ----------------------------------------------------------------------------
// Wakeup checker
// Watches the item, result and register-write channels of the periodic
// event wakeup block, keeps its own copy of the periods, match times and
// waiting sets, and compares every result transfer with the oldest
// predicted result. Hands the failure and outstanding-result counts to the
// testbench top.
// ----------------------------------------------------------------------------
module pew_wake_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pew_in_if    item_i,
  pew_out_if   wake_i,
  pew_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pew_pkg::*;

  localparam int SRC_NUM = 4;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD [SRC_NUM] = '{16'd100, 16'd200, 16'd500, 16'd50};

  typedef struct packed {
    logic [WOKEN_W-1:0] woken;
    logic [FIRED_W-1:0] fired;
  } wake_result_t;

  logic [PERIOD_W-1:0] period_q  [SRC_NUM];
  logic [NOW_W-1:0]    match_q   [SRC_NUM];
  logic [WOKEN_W-1:0]  waiting_q [SRC_NUM];
  wake_result_t        wake_due_q [$];
  int                  fails;

  // Smallest whole number of periods past now; zero period counts as one.
  function automatic logic [NOW_W-1:0] catch_up_match(input logic [NOW_W-1:0] cur,
                                                      input logic [NOW_W-1:0] now,
                                                      input logic [PERIOD_W-1:0] preg);
    logic [63:0]      per;
    logic [63:0]      steps;
    logic [63:0]      nxt;
    logic [NOW_W-1:0] span;
    per   = (preg == '0) ? 64'd1 : {48'd0, preg};
    span  = now - cur;
    steps = {32'd0, span} / per + 64'd1;
    nxt   = {32'd0, cur} + steps * per;
    return (nxt > {32'd0, TIME_MAX}) ? TIME_MAX : nxt[NOW_W-1:0];
  endfunction

  // Fire every source whose match time is reached and release its waiters.
  function automatic wake_result_t release_due(input logic [NOW_W-1:0] now);
    wake_result_t res;
    res = '0;
    for (int s = 0; s < SRC_NUM; s++) begin
      if (now >= match_q[s]) begin
        match_q[s]   = catch_up_match(match_q[s], now, period_q[s]);
        res.woken    = res.woken | waiting_q[s];
        waiting_q[s] = '0;
        res.fired[s] = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wake_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SRC_NUM; s++) begin
        period_q[s]  = RESET_PERIOD[s];
        match_q[s]   = {16'd0, RESET_PERIOD[s]};
        waiting_q[s] = '0;
      end
      wake_due_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready && cfg_i.index < PREG_NUM)
        period_q[cfg_i.index[PREG_IDX_W-1:0]] = cfg_i.data;

      if (item_i.valid && item_i.ready) begin
        if (item_i.func == FUNC_WAIT) begin
          waiting_q[item_i.src_id][item_i.task_req] = 1'b1;
          wake_due_q.push_back('0);
        end else begin
          wake_due_q.push_back(release_due(item_i.now_ms));
        end
      end

      if (wake_i.valid && wake_i.ready) begin
        if (wake_due_q.size() == 0) begin
          $display("%0t: unexpected result woken_tasks %h fired_sources %h",
                   $time, wake_i.woken_tasks, wake_i.fired_sources);
          fails++;
        end else begin
          want = wake_due_q.pop_front();
          if (want.woken != wake_i.woken_tasks) begin
            $display("%0t: woken_tasks expected %h actual %h",
                     $time, want.woken, wake_i.woken_tasks);
            fails++;
          end
          if (want.fired != wake_i.fired_sources) begin
            $display("%0t: fired_sources expected %h actual %h",
                     $time, want.fired, wake_i.fired_sources);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= wake_due_q.size();
    end
  end

endmodule

// ===== verif/periodic_event_wakeup_test.sv =====
// ----------------------------------------------------------------------------
// Periodic event wakeup testbench
// Drives wait and tick items into the block in random bursts, stalls the
// result side on a changing pattern, reprograms the four periods between
// phases, and lets the wakeup checker predict and compare every result.
// ----------------------------------------------------------------------------
module periodic_event_wakeup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pew_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 230;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   wake_pending;
  int   burst_left;
  int   ready_mode;
  int   ready_hold;
  int   ready_cnt;
  logic [NOW_W-1:0] clock_ms;

  pew_in_if  item_ch ();
  pew_out_if wake_ch ();
  pew_cfg_if cfg_ch ();

  periodic_event_wakeup u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_ch),
    .out_o  (wake_ch),
    .cfg_i  (cfg_ch)
  );

  pew_wake_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_i       (item_ch),
    .wake_i       (wake_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (wake_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result-side stalls: switch among always ready, coin flip, mostly stalled and
  // a fixed duty pattern, picking a new mode when the hold count runs out.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(50, 400);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    ready_cnt <= ready_cnt + 1;
    case (ready_mode)
      0:       wake_ch.ready <= 1'b1;
      1:       wake_ch.ready <= 1'($urandom_range(0, 1));
      2:       wake_ch.ready <= ($urandom_range(0, 3) == 0);
      default: wake_ch.ready <= (ready_cnt[2:0] != 3'd0) && (ready_cnt[2:0] != 3'd5);
    endcase
  end

  // Present one item and hold it until the transfer. Valid stays high on
  // return so a back-to-back item follows with no gap in valid; burst gaps drop it.
  task automatic push_item(input logic [FUNC_W-1:0] fn, input logic [NOW_W-1:0] now,
                           input logic [SRC_W-1:0] src, input logic [TASK_W-1:0] tsk);
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 16);
    end
    item_ch.valid    <= 1'b1;
    item_ch.func     <= fn;
    item_ch.now_ms   <= now;
    item_ch.src_id   <= src;
    item_ch.task_req <= tsk;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Park a task on a source; the time field is don't-care, so randomize it.
  task automatic park(input logic [SRC_W-1:0] src, input logic [TASK_W-1:0] tsk);
    push_item(FUNC_WAIT, $urandom, src, tsk);
  endtask

  // Tick with a count; source and task fields are ignored, so randomize them.
  task automatic tick(input logic [NOW_W-1:0] now);
    push_item(FUNC_TICK, now, SRC_W'($urandom_range(0, 3)), TASK_W'($urandom_range(0, 63)));
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (wake_pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Program all four periods, then poke an index past the register file,
  // which must change nothing.
  task automatic load_periods(input logic [PERIOD_W-1:0] pa, input logic [PERIOD_W-1:0] pb,
                              input logic [PERIOD_W-1:0] pc, input logic [PERIOD_W-1:0] pd);
    cfg_write(REG_PERIOD_A, pa);
    cfg_write(REG_PERIOD_B, pb);
    cfg_write(REG_PERIOD_C, pc);
    cfg_write(REG_PERIOD_D, pd);
    cfg_write(CFG_IDX_W'($urandom_range(PREG_NUM, 255)), CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Favor the extremes: zero (acts as one), one, and the largest period.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return 16'd1;
    if (roll < 40) return '1;
    if (roll < 70) return PERIOD_W'($urandom_range(2, 300));
    return PERIOD_W'($urandom_range(2, 65535));
  endfunction

  initial begin
    int roll;
    item_ch.valid    = 1'b0;
    item_ch.func     = FUNC_TICK;
    item_ch.now_ms   = '0;
    item_ch.src_id   = '0;
    item_ch.task_req = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    wake_ch.ready    = 1'b0;
    ready_mode       = 0;
    ready_hold       = 0;
    ready_cnt        = 0;
    burst_left       = 0;
    rst_n            = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part on the reset periods (100, 200, 500, 50).
    tick('0);                // nothing due yet
    park(2'd0, 6'd0);
    park(2'd0, 6'd0);        // same task twice stays parked once
    park(2'd1, 6'd63);
    park(2'd2, 6'd31);
    park(2'd3, 6'd32);
    tick(32'd49);            // one short of source 3
    tick(32'd50);            // source 3 alone fires
    tick(32'd250);           // sources 0, 1, 3 fire; 0 and 3 catch up by several periods
    park(2'd2, 6'd5);
    tick(32'd500);           // source 2 fires with two waiters
    drain();

    // New periods do not move match times already set; zero acts as one.
    load_periods('0, '1, 16'd1, 16'd7);
    park(2'd0, 6'd10);
    park(2'd1, 6'd20);
    tick(32'd301);
    tick(32'd302);
    tick(32'd302);           // nothing due on a repeated count
    tick(32'd100_000);       // all four fire; the short periods catch up by many periods
    clock_ms = 32'd100_000;

    // Random phases: mostly forward-moving ticks with waits mixed in, a few
    // backward ticks as noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0)
        load_periods(16'd1, 16'd3, 16'd17, 16'd250);
      else if (ph == 1)
        load_periods('1, '1, '0, '0);
      else
        load_periods(pick_period(), pick_period(), pick_period(), pick_period());
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          park(SRC_W'($urandom_range(0, 3)), TASK_W'($urandom_range(0, 63)));
        end else if (roll < 97) begin
          roll = $urandom_range(0, 99);
          if (roll < 70)
            clock_ms += $urandom_range(0, 300);
          else if (roll < 92)
            clock_ms += $urandom_range(0, 70_000);
          else
            clock_ms += $urandom_range(0, 1 << 22);
          tick(clock_ms);
        end else begin
          tick(clock_ms - $urandom_range(0, 500));
        end
      end
    end

    // Top of the time range: match times saturate at the maximum and keep
    // firing on every tick at the maximum.
    drain();
    load_periods('1, 16'd1, '0, 16'd40_000);
    park(2'd0, 6'd1);
    park(2'd1, 6'd2);
    park(2'd2, 6'd3);
    park(2'd3, 6'd4);
    tick(TIME_MAX - 32'd1);
    park(2'd0, 6'd7);
    tick(TIME_MAX);
    park(2'd1, 6'd9);
    park(2'd3, 6'd62);
    tick(TIME_MAX);
    repeat (60) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        park(SRC_W'($urandom_range(0, 3)), TASK_W'($urandom_range(0, 63)));
      else if (roll < 70)
        tick(TIME_MAX - $urandom_range(0, 200_000));
      else
        tick($urandom);
    end

    // Let the tail settle after the last result.
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pew_pkg.sv
src/pew_chan_if.sv
src/pew_rem.sv
src/pew_state_mem.sv
src/periodic_event_wakeup.sv
verif/pew_wake_checker.sv
verif/periodic_event_wakeup_test.sv
